// ===== rtl/mcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus coil poll master package
// Shared codes, frame layout helpers and types for the coil poll master.
// ----------------------------------------------------------------------------
package mcpm_pkg;

  localparam logic [1:0] KIND_POLL    = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [7:0] FUNC_READ_COILS  = 8'h01;
  localparam logic [7:0] FUNC_WRITE_COILS = 8'h0F;
  localparam logic [7:0] READ_QTY         = 8'h10;
  localparam logic [7:0] READ_BYTE_CNT    = 8'h02;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic REG_DEV_ADDR  = 1'b0;
  localparam logic REG_BIT_COUNT = 1'b1;

  localparam logic [7:0] DEV_ADDR_RST  = 8'd4;
  localparam logic [4:0] BIT_COUNT_RST = 5'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_CRC_WAIT,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic        is_write;
    logic        ok;
    logic [15:0] coils;
  } rsp_t;

  function automatic logic [2:0] data_byte_cnt(logic [4:0] cnt);
    logic [5:0] sum;
    sum = {1'b0, cnt} + 6'd7;
    return sum[5:3];
  endfunction

  function automatic logic [3:0] frame_len(logic wr, logic [4:0] cnt);
    logic [3:0] len;
    if (!wr) begin
      len = 4'd6;
    end else if (data_byte_cnt(cnt) == 3'd2) begin
      len = 4'd9;
    end else begin
      len = 4'd8;
    end
    return len;
  endfunction

  function automatic logic [7:0] frame_byte(logic [3:0] idx, logic wr, logic [7:0] addr,
                                            logic [4:0] cnt, logic [15:0] cmd);
    logic [7:0] b;
    case (idx)
      4'd0:    b = addr;
      4'd1:    b = wr ? FUNC_WRITE_COILS : FUNC_READ_COILS;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h00;
      4'd5:    b = wr ? {3'b000, cnt} : READ_QTY;
      4'd6:    b = {5'b00000, data_byte_cnt(cnt)};
      4'd7:    b = cmd[7:0];
      4'd8:    b = cmd[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] coil_mask(logic [4:0] cnt);
    logic [15:0] m;
    for (int i = 0; i < 16; i++) begin
      m[i] = (5'(i) < cnt);
    end
    return m;
  endfunction

endpackage

// ===== rtl/mcpm_crc.sv =====
// ----------------------------------------------------------------------------
// Bit-serial CRC-16 unit
// Folds one request byte into a reflected CRC-16, one bit per cycle.
// ----------------------------------------------------------------------------
module mcpm_crc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        init_i,
  input  logic        start_i,
  input  logic [7:0]  byte_i,
  output logic        busy_o,
  output logic [15:0] crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  sh_q, sh_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        fb;

  assign fb = crc_q[0] ^ sh_q[0];

  always_comb begin
    crc_d  = crc_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (init_i) begin
      crc_d = mcpm_pkg::CRC_INIT;
    end else if (busy_q) begin
      crc_d = {1'b0, crc_q[15:1]} ^ (fb ? mcpm_pkg::CRC_POLY : 16'h0000);
      sh_d  = {1'b0, sh_q[7:1]};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
    if (start_i) begin
      sh_d   = byte_i;
      cnt_d  = 3'd0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= mcpm_pkg::CRC_INIT;
      cnt_q  <= 3'd0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign busy_o = busy_q;
  assign crc_o  = crc_q;

endmodule

// ===== rtl/mcpm_rx.sv =====
// ----------------------------------------------------------------------------
// Response buffer and checker
// Holds up to eight response bytes and checks length and header.
// ----------------------------------------------------------------------------
module mcpm_rx (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          byte_i,
  input  logic                clear_i,
  input  logic [7:0]          dev_addr_i,
  input  logic [4:0]          bit_count_i,
  output mcpm_pkg::rsp_t      rsp_o
);

  logic [7:0] buf_q [8];
  logic [3:0] len_q, len_d;
  logic       wr_ok, rd_ok;

  always_ff @(posedge clk_i) begin
    if (push_i && !len_q[3]) begin
      buf_q[len_q[2:0]] <= byte_i;
    end
  end

  always_comb begin
    len_d = len_q;
    if (clear_i) begin
      len_d = 4'd0;
    end else if (push_i && len_q != 4'd9) begin
      len_d = len_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 4'd0;
    end else begin
      len_q <= len_d;
    end
  end

  assign wr_ok = (len_q == 4'd8) && (buf_q[0] == dev_addr_i)
              && (buf_q[1] == mcpm_pkg::FUNC_WRITE_COILS)
              && (buf_q[2] == 8'h00) && (buf_q[4] == 8'h00)
              && (buf_q[5] == {3'b000, bit_count_i});
  assign rd_ok = (len_q == 4'd7) && (buf_q[0] == dev_addr_i)
              && (buf_q[1] == mcpm_pkg::FUNC_READ_COILS)
              && (buf_q[2] == mcpm_pkg::READ_BYTE_CNT);

  always_comb begin
    rsp_o.is_write = (len_q >= 4'd2) && (buf_q[1] == mcpm_pkg::FUNC_WRITE_COILS);
    rsp_o.ok       = rsp_o.is_write ? wr_ok : rd_ok;
    rsp_o.coils    = {buf_q[4], buf_q[3]};
  end

endmodule

// ===== rtl/modbus_coil_poll_master.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU coil poll master
// Builds read-coils and write-coils requests with CRC and checks responses.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on in_valid_i/in_ready_o with kind_i and rx_byte_i.
//   A poll emits a whole request frame as transmit-byte results, the last one
//   (CRC high byte) flagged by tx_last_o. A response byte is buffered and
//   gives no result. Response complete and timeout each give one status
//   report carrying response_ok_o, coil_state_o and both counters.
//   A response byte leaves the block idle and ready for the next request. A
//   done or timeout request moves to the report state, which loads the report
//   into the output register once the output slot is free. A poll loads each
//   header byte into the output register and lets the bit-serial CRC unit
//   fold it in before the next; the CRC low and high bytes follow. One
//   request is worked on at a time; in_ready_o rises once the last result is
//   in the output register, even while that result waits.
//   If the receiver stalls, the block holds the current result and waits.
//   Reset restores device_address 4, bit_count 8, clears counters, coil
//   state and the pending write. Registers are written over the APB port.
// ----------------------------------------------------------------------------
module modbus_coil_poll_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        response_ok_o,
  output logic [15:0] coil_state_o,
  output logic [31:0] requests_sent_o,
  output logic [31:0] failures_o
);

  mcpm_pkg::state_e state_q, state_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  dev_addr_q;
  logic [4:0]  bit_count_q;
  logic        wr_pend_q, wr_pend_d;
  logic [15:0] cmd_q, cmd_d;
  logic        toggle_q, toggle_d;
  logic [15:0] coils_q, coils_d;
  logic [31:0] sent_q, sent_d;
  logic [31:0] fail_q, fail_d;
  logic        rpt_ok_q, rpt_ok_d;

  logic        out_valid_q, out_valid_d;
  logic        rk_q, rk_d;
  logic [7:0]  tx_q, tx_d;
  logic        last_q, last_d;
  logic        ok_q, ok_d;
  logic [15:0] ocoils_q, ocoils_d;
  logic [31:0] osent_q, osent_d;
  logic [31:0] ofail_q, ofail_d;

  logic        in_acc, slot_free, cfg_wr;
  logic        crc_init, crc_start, crc_busy;
  logic [15:0] crc;
  logic        rx_push, rx_clear;
  logic [7:0]  cur_byte;
  logic [3:0]  flen;
  mcpm_pkg::rsp_t rsp;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_ready_o = (state_q == mcpm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign cur_byte   = mcpm_pkg::frame_byte(idx_q, wr_pend_q, dev_addr_q, bit_count_q, cmd_q);
  assign flen       = mcpm_pkg::frame_len(wr_pend_q, bit_count_q);

  always_comb begin
    if (paddr[2] == mcpm_pkg::REG_BIT_COUNT) begin
      prdata = {27'd0, bit_count_q};
    end else begin
      prdata = {24'd0, dev_addr_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= mcpm_pkg::DEV_ADDR_RST;
      bit_count_q <= mcpm_pkg::BIT_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == mcpm_pkg::REG_BIT_COUNT) begin
        bit_count_q <= pwdata[4:0];
      end else begin
        dev_addr_q <= pwdata[7:0];
      end
    end
  end

  mcpm_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .init_i  (crc_init),
    .start_i (crc_start),
    .byte_i  (cur_byte),
    .busy_o  (crc_busy),
    .crc_o   (crc)
  );

  mcpm_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rx_push),
    .byte_i      (rx_byte_i),
    .clear_i     (rx_clear),
    .dev_addr_i  (dev_addr_q),
    .bit_count_i (bit_count_q),
    .rsp_o       (rsp)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    wr_pend_d   = wr_pend_q;
    cmd_d       = cmd_q;
    toggle_d    = toggle_q;
    coils_d     = coils_q;
    sent_d      = sent_q;
    fail_d      = fail_q;
    rpt_ok_d    = rpt_ok_q;
    crc_init    = 1'b0;
    crc_start   = 1'b0;
    rx_push     = 1'b0;
    rx_clear    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    rk_d        = rk_q;
    tx_d        = tx_q;
    last_d      = last_q;
    ok_d        = ok_q;
    ocoils_d    = ocoils_q;
    osent_d     = osent_q;
    ofail_d     = ofail_q;
    case (state_q)
      mcpm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (kind_i)
            mcpm_pkg::KIND_POLL: begin
              sent_d   = sent_q + 32'd1;
              rx_clear = 1'b1;
              crc_init = 1'b1;
              idx_d    = 4'd0;
              state_d  = mcpm_pkg::ST_DATA;
            end
            mcpm_pkg::KIND_BYTE: begin
              rx_push = 1'b1;
            end
            mcpm_pkg::KIND_DONE: begin
              rx_clear = 1'b1;
              rpt_ok_d = rsp.ok;
              if (rsp.is_write) begin
                if (rsp.ok) begin
                  wr_pend_d = 1'b0;
                end else begin
                  fail_d = fail_q + 32'd1;
                end
              end else begin
                if (rsp.ok) begin
                  coils_d = rsp.coils;
                end else begin
                  fail_d = fail_q + 32'd1;
                end
                if (toggle_q) begin
                  cmd_d = 16'h0000;
                end else begin
                  cmd_d = cmd_q | mcpm_pkg::coil_mask(bit_count_q);
                end
                toggle_d  = !toggle_q;
                wr_pend_d = 1'b1;
              end
              state_d = mcpm_pkg::ST_REPORT;
            end
            mcpm_pkg::KIND_TIMEOUT: begin
              fail_d   = fail_q + 32'd1;
              rx_clear = 1'b1;
              rpt_ok_d = 1'b0;
              state_d  = mcpm_pkg::ST_REPORT;
            end
            default: begin
              state_d = mcpm_pkg::ST_IDLE;
            end
          endcase
        end
      end
      mcpm_pkg::ST_DATA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          rk_d        = 1'b0;
          tx_d        = cur_byte;
          last_d      = 1'b0;
          ok_d        = 1'b0;
          ocoils_d    = 16'h0000;
          osent_d     = 32'd0;
          ofail_d     = 32'd0;
          crc_start   = 1'b1;
          idx_d       = idx_q + 4'd1;
          state_d     = mcpm_pkg::ST_CRC_WAIT;
        end
      end
      mcpm_pkg::ST_CRC_WAIT: begin
        if (!crc_busy) begin
          state_d = (idx_q == flen) ? mcpm_pkg::ST_CRC_LO : mcpm_pkg::ST_DATA;
        end
      end
      mcpm_pkg::ST_CRC_LO: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          rk_d        = 1'b0;
          tx_d        = crc[7:0];
          last_d      = 1'b0;
          ok_d        = 1'b0;
          ocoils_d    = 16'h0000;
          osent_d     = 32'd0;
          ofail_d     = 32'd0;
          state_d     = mcpm_pkg::ST_CRC_HI;
        end
      end
      mcpm_pkg::ST_CRC_HI: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          rk_d        = 1'b0;
          tx_d        = crc[15:8];
          last_d      = 1'b1;
          ok_d        = 1'b0;
          ocoils_d    = 16'h0000;
          osent_d     = 32'd0;
          ofail_d     = 32'd0;
          state_d     = mcpm_pkg::ST_IDLE;
        end
      end
      mcpm_pkg::ST_REPORT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          rk_d        = 1'b1;
          tx_d        = 8'h00;
          last_d      = 1'b0;
          ok_d        = rpt_ok_q;
          ocoils_d    = coils_q;
          osent_d     = sent_q;
          ofail_d     = fail_q;
          state_d     = mcpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcpm_pkg::ST_IDLE;
      idx_q       <= 4'd0;
      wr_pend_q   <= 1'b0;
      cmd_q       <= 16'h0000;
      toggle_q    <= 1'b0;
      coils_q     <= 16'h0000;
      sent_q      <= 32'd0;
      fail_q      <= 32'd0;
      rpt_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      wr_pend_q   <= wr_pend_d;
      cmd_q       <= cmd_d;
      toggle_q    <= toggle_d;
      coils_q     <= coils_d;
      sent_q      <= sent_d;
      fail_q      <= fail_d;
      rpt_ok_q    <= rpt_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q     <= rk_d;
    tx_q     <= tx_d;
    last_q   <= last_d;
    ok_q     <= ok_d;
    ocoils_q <= ocoils_d;
    osent_q  <= osent_d;
    ofail_q  <= ofail_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = rk_q;
  assign tx_byte_o       = tx_q;
  assign tx_last_o       = last_q;
  assign response_ok_o   = ok_q;
  assign coil_state_o    = ocoils_q;
  assign requests_sent_o = osent_q;
  assign failures_o      = ofail_q;

  a_idle_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcpm_pkg::ST_IDLE) |-> !crc_busy)
    else $error("crc unit busy while idle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 4'd9)
    else $error("frame index out of range");

  a_poll_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == mcpm_pkg::KIND_POLL) |=> (state_q == mcpm_pkg::ST_DATA))
    else $error("poll did not start a frame");

  a_last_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> !rk_q)
    else $error("last flag on a status report");

endmodule
